[src/fsng_pkg.sv]
// Constants and pipeline item type for the FAT short name generator.
`default_nettype none
package fsng_pkg;

    localparam int BASE_CHARS = 8;
    localparam int EXT_CHARS  = 3;
    localparam int BLEN_W     = 4;
    localparam int ELEN_W     = 2;
    localparam int TAIL_W     = 20;
    localparam int BCD_DIGITS = 7;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DD_STAGES  = 3;
    localparam int DD_PER_STG = 7;
    localparam int PIPE_DEPTH = DD_STAGES + 1;

    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic [8*BASE_CHARS-1:0] base_chars;
        logic [BLEN_W-1:0]       base_size;
        logic [8*EXT_CHARS-1:0]  ext_chars;
        logic [ELEN_W-1:0]       ext_len;
        logic                    tail_nz;
        logic [BCD_W-1:0]        bcd;
        logic [TAIL_W-1:0]       bin;
    } t_item;

endpackage
`default_nettype wire

[src/fat_short_name_generator_unit.sv]
// Streaming FAT 8.3 short name generator with pipelined decimal tail conversion.
// Each name passes the stage registers and the output register to m_axis_tvalid.
// Throughput: one byte per cycle unless the output stalls; a name may end in every cycle.
// The decimal tail is built by a 3-stage shift-add-3 pipeline, 7 steps per stage at most.
// Reset (synchronous, active low) clears the name state and all pipeline valid flags.
`default_nettype none
module fat_short_name_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] name_byte, [27:8] tail_index, [31:28] zero
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] base_chars, [67:64] base_length, [91:68] ext_chars, [93:92] ext_length,
    // [95:94] zero
    output logic [95:0]      m_axis_tdata
);

    localparam int BC = fsng_pkg::BASE_CHARS;
    localparam int EC = fsng_pkg::EXT_CHARS;
    localparam int BW = fsng_pkg::BLEN_W;
    localparam int EW = fsng_pkg::ELEN_W;
    localparam int PD = fsng_pkg::PIPE_DEPTH;
    localparam int TW = fsng_pkg::TAIL_W;
    localparam int DW = fsng_pkg::BCD_W;

    function automatic logic [DW-1:0] dd_step(input logic [DW-1:0] v, input logic b);
        logic [DW-1:0] t;
        t = v;
        for (int d = 0; d < fsng_pkg::BCD_DIGITS; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[DW-2:0], b};
    endfunction

    // name state
    logic [7:0]    r_base_buf [BC];
    logic [BW-1:0] r_base_cnt;
    logic [BW-1:0] r_base_dot;
    logic          r_dot_seen;
    logic [7:0]    r_ext_buf [EC];
    logic [EW-1:0] r_ext_cnt;

    logic [7:0]    n_base_buf [BC];
    logic [BW-1:0] n_base_cnt;
    logic [BW-1:0] n_base_dot;
    logic          n_dot_seen;
    logic [7:0]    n_ext_buf [EC];
    logic [EW-1:0] n_ext_cnt;

    logic [7:0]    in_byte;
    logic [TW-1:0] in_tail;
    logic          in_acc;
    logic          is_alnum;
    logic [7:0]    up_byte;
    logic [BW-1:0] snap_len;

    fsng_pkg::t_item n_first;
    fsng_pkg::t_item r_stg [PD];
    fsng_pkg::t_item n_stg [PD];
    logic [PD-1:0]   r_vld;
    logic [PD-1:0]   rdy;

    fsng_pkg::t_item r_out;
    fsng_pkg::t_item n_out;
    logic            r_out_vld;
    logic            out_rdy;

    assign in_byte = s_axis_tdata[7:0];
    assign in_tail = s_axis_tdata[8 +: TW];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign out_rdy = !r_out_vld || m_axis_tready;

    always_comb begin
        rdy[PD-1] = !r_vld[PD-1] || out_rdy;
        for (int k = PD - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];

    // byte classification and state update
    always_comb begin
        is_alnum = 1'b0;
        up_byte  = in_byte;
        if (in_byte inside {[8'h30:8'h39], [8'h41:8'h5a]}) begin
            is_alnum = 1'b1;
        end else if (in_byte inside {[8'h61:8'h7a]}) begin
            is_alnum = 1'b1;
            up_byte  = in_byte - 8'd32;
        end

        n_base_buf = r_base_buf;
        n_base_cnt = r_base_cnt;
        n_base_dot = r_base_dot;
        n_dot_seen = r_dot_seen;
        n_ext_buf  = r_ext_buf;
        n_ext_cnt  = r_ext_cnt;

        if (in_byte == fsng_pkg::CHAR_DOT) begin
            n_dot_seen = 1'b1;
            n_base_dot = r_base_cnt;
            n_ext_cnt  = '0;
            for (int i = 0; i < EC; i++) begin
                n_ext_buf[i] = '0;
            end
        end else if (is_alnum) begin
            if (r_base_cnt < BW'(BC)) begin
                for (int i = 0; i < BC; i++) begin
                    if (r_base_cnt == BW'(i)) begin
                        n_base_buf[i] = up_byte;
                    end
                end
                n_base_cnt = r_base_cnt + BW'(1);
            end
            if (r_dot_seen && (r_ext_cnt < EW'(EC))) begin
                for (int i = 0; i < EC; i++) begin
                    if (r_ext_cnt == EW'(i)) begin
                        n_ext_buf[i] = up_byte;
                    end
                end
                n_ext_cnt = r_ext_cnt + EW'(1);
            end
        end

        snap_len = n_dot_seen ? n_base_dot : n_base_cnt;
        n_first = '0;
        for (int i = 0; i < BC; i++) begin
            if (BW'(i) < snap_len) begin
                n_first.base_chars[8*i +: 8] = n_base_buf[i];
            end
        end
        n_first.base_size = snap_len;
        for (int i = 0; i < EC; i++) begin
            if (EW'(i) < n_ext_cnt) begin
                n_first.ext_chars[8*i +: 8] = n_ext_buf[i];
            end
        end
        n_first.ext_len = n_ext_cnt;
        n_first.tail_nz = (in_tail != '0);
        n_first.bcd     = '0;
        n_first.bin     = in_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BC; i++) begin
                r_base_buf[i] <= '0;
            end
            for (int i = 0; i < EC; i++) begin
                r_ext_buf[i] <= '0;
            end
            r_base_cnt <= '0;
            r_base_dot <= '0;
            r_dot_seen <= 1'b0;
            r_ext_cnt  <= '0;
        end else if (in_acc) begin
            if (s_axis_tlast) begin
                for (int i = 0; i < BC; i++) begin
                    r_base_buf[i] <= '0;
                end
                for (int i = 0; i < EC; i++) begin
                    r_ext_buf[i] <= '0;
                end
                r_base_cnt <= '0;
                r_base_dot <= '0;
                r_dot_seen <= 1'b0;
                r_ext_cnt  <= '0;
            end else begin
                r_base_buf <= n_base_buf;
                r_ext_buf  <= n_ext_buf;
                r_base_cnt <= n_base_cnt;
                r_base_dot <= n_base_dot;
                r_dot_seen <= n_dot_seen;
                r_ext_cnt  <= n_ext_cnt;
            end
        end
    end

    // binary to BCD, a slice of the steps per stage
    always_comb begin
        n_stg[0] = n_first;
        for (int k = 1; k < PD; k++) begin
            n_stg[k] = r_stg[k-1];
            for (int j = 0; j < fsng_pkg::DD_PER_STG; j++) begin
                if ((k - 1) * fsng_pkg::DD_PER_STG + j < TW) begin
                    n_stg[k].bcd = dd_step(n_stg[k].bcd, n_stg[k].bin[TW-1]);
                    n_stg[k].bin = {n_stg[k].bin[TW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= in_acc && s_axis_tlast;
            end
            for (int k = 1; k < PD; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PD; k++) begin
            if (rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // tail placement
    logic [2:0]    nd;
    logic [BW-1:0] nl;
    logic          fits;
    logic [BW-1:0] start;
    logic [BW-1:0] new_len;
    logic [BW-1:0] tj;
    logic [3:0]    dig;
    logic [7:0]    ch;

    always_comb begin
        n_out = r_stg[PD-1];
        nd    = '0;
        for (int d = 0; d < fsng_pkg::BCD_DIGITS; d++) begin
            if (r_stg[PD-1].bcd[4*d +: 4] != 4'd0) begin
                nd = 3'(d + 1);
            end
        end
        nl      = BW'(nd) + BW'(1);
        fits    = ({1'b0, r_stg[PD-1].base_size} + {1'b0, nl}) <= (BW+1)'(BC);
        start   = fits ? r_stg[PD-1].base_size : ((BW'(BC) > nl) ? (BW'(BC) - nl) : '0);
        new_len = fits ? (r_stg[PD-1].base_size + nl) : BW'(BC);
        tj      = '0;
        dig     = '0;
        ch      = '0;
        if (r_stg[PD-1].tail_nz) begin
            n_out.base_size = new_len;
            for (int i = 0; i < BC; i++) begin
                tj  = BW'(i) - start;
                dig = '0;
                for (int d = 0; d < fsng_pkg::BCD_DIGITS; d++) begin
                    if (BW'(d) == BW'(nd) - tj) begin
                        dig = r_stg[PD-1].bcd[4*d +: 4];
                    end
                end
                if (BW'(i) < start) begin
                    ch = r_stg[PD-1].base_chars[8*i +: 8];
                end else if (BW'(i) < new_len) begin
                    ch = (tj == '0) ? fsng_pkg::CHAR_TILDE : (fsng_pkg::CHAR_ZERO + 8'(dig));
                end else begin
                    ch = '0;
                end
                n_out.base_chars[8*i +: 8] = ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= r_vld[PD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out.ext_len, r_out.ext_chars, r_out.base_size,
                            r_out.base_chars};

endmodule
`default_nettype wire

[tb/fat_short_name_generator_unit_tb.sv]
// Self-checking testbench for the streaming FAT 8.3 short name generator.
`timescale 1ns / 100ps
module fat_short_name_generator_unit_tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int STALL_CYCLES = 300;
    localparam int STALL_AFTER  = 25;
    localparam int NAME_BYTES   = 675;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        logic [19:0] tail;
    } t_name_req;

    typedef struct packed {
        logic [63:0] base_chars;
        logic [3:0]  base_length;
        logic [23:0] ext_chars;
        logic [1:0]  ext_length;
    } t_short_name;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [7:0] name_byte, [27:8] tail_index, [31:28] zero
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;          // [63:0] base, [67:64] base len, [91:68] ext, [93:92] ext len

    t_name_req   name_req_q[$];
    t_short_name short_name_q[$];

    logic [7:0]  nm_base [fsng_pkg::BASE_CHARS] = '{default: 8'h00};
    logic [7:0]  nm_ext [fsng_pkg::EXT_CHARS] = '{default: 8'h00};
    int          nm_base_cnt = 0;
    int          nm_dot_cnt = 0;
    logic        nm_dot = 1'b0;
    int          nm_ext_cnt = 0;

    int          mismatches = 0;
    int          names_seen = 0;
    int          src_wait = 0;
    int          src_burst = 0;
    int          sink_wait = 0;
    int          sink_burst = 0;
    int          stall_left = 0;
    logic        stall_done = 1'b0;
    int          quiet_cycles = 0;

    fat_short_name_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] alnum_char();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return 8'(8'h61 + $urandom_range(0, 25));
        if (r == 1) return 8'(8'h41 + $urandom_range(0, 25));
        return 8'(fsng_pkg::CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return alnum_char();
        if (r == 6) return fsng_pkg::CHAR_DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [19:0] draw_tail();
        case ($urandom_range(0, 5))
            0, 1: return 20'd0;
            2: return 20'($urandom_range(1, 9));
            3: return 20'($urandom_range(10, 9999));
            4: return 20'($urandom_range(1, 999999));
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    task automatic add_name(input logic [7:0] txt[$], input logic [19:0] tail);
        t_name_req req;
        for (int i = 0; i < txt.size(); i++) begin
            req.ch   = txt[i];
            req.last = (i == txt.size() - 1);
            req.tail = req.last ? tail : 20'($urandom_range(0, 20'hFFFFF));
            name_req_q.push_back(req);
        end
    endtask

    task automatic add_text(input string s, input logic [19:0] tail);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        add_name(txt, tail);
    endtask

    // Track one name byte; on the last byte build the short name and clear the state.
    task automatic absorb_name_byte(input logic [7:0] ch, input logic last,
                                    input logic [19:0] tail);
        logic [7:0]  up;
        logic [7:0]  work [fsng_pkg::BASE_CHARS];
        logic [7:0]  txt [8];
        logic [19:0] v;
        int          nd;
        int          nl;
        int          blen;
        int          pos;
        t_short_name sn;
        if (ch == fsng_pkg::CHAR_DOT) begin
            nm_dot     = 1'b1;
            nm_dot_cnt = nm_base_cnt;
            nm_ext_cnt = 0;
            nm_ext     = '{default: 8'h00};
        end else if ((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
                     (ch >= "a" && ch <= "z")) begin
            up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
            if (nm_base_cnt < fsng_pkg::BASE_CHARS) begin
                nm_base[nm_base_cnt] = up;
                nm_base_cnt++;
            end
            if (nm_dot && nm_ext_cnt < fsng_pkg::EXT_CHARS) begin
                nm_ext[nm_ext_cnt] = up;
                nm_ext_cnt++;
            end
        end
        if (!last) return;

        work = '{default: 8'h00};
        blen = nm_dot ? nm_dot_cnt : nm_base_cnt;
        for (int i = 0; i < blen; i++) work[i] = nm_base[i];
        if (tail != 0) begin
            v  = tail;
            nd = 0;
            while (v != 0) begin
                nd++;
                v = v / 10;
            end
            v      = tail;
            txt[0] = fsng_pkg::CHAR_TILDE;
            for (int k = nd; k >= 1; k--) begin
                txt[k] = fsng_pkg::CHAR_ZERO + 8'(v % 10);
                v      = v / 10;
            end
            nl = nd + 1;
            if (blen + nl <= fsng_pkg::BASE_CHARS) begin
                for (int k = 0; k < nl; k++) work[blen + k] = txt[k];
                blen += nl;
            end else begin
                pos = fsng_pkg::BASE_CHARS - nl;
                for (int k = 0; k < nl; k++) work[pos + k] = txt[k];
                blen = fsng_pkg::BASE_CHARS;
            end
        end

        sn = '0;
        for (int i = 0; i < blen; i++) sn.base_chars[8*i +: 8] = work[i];
        sn.base_length = 4'(blen);
        for (int i = 0; i < nm_ext_cnt; i++) sn.ext_chars[8*i +: 8] = nm_ext[i];
        sn.ext_length = 2'(nm_ext_cnt);
        short_name_q.push_back(sn);

        nm_base     = '{default: 8'h00};
        nm_ext      = '{default: 8'h00};
        nm_base_cnt = 0;
        nm_dot_cnt  = 0;
        nm_dot      = 1'b0;
        nm_ext_cnt  = 0;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Sender
    always @(posedge i_clk) begin
        t_name_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
            src_burst     <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_wait != 0) begin
                src_wait      <= src_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (name_req_q.size() != 0) begin
                req = name_req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'h0, req.tail, req.ch};
                s_axis_tlast  <= req.last;
                if (src_burst != 0) begin
                    src_wait  <= 0;
                    src_burst <= src_burst - 1;
                end else begin
                    if ($urandom_range(0, 24) == 0) src_burst <= 30;
                    src_wait <= $urandom_range(0, 10);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
            sink_burst    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (sink_burst != 0) begin
                w = 0;
                sink_burst <= sink_burst - 1;
            end else begin
                if ($urandom_range(0, 24) == 0) sink_burst <= 30;
                w = $urandom_range(0, 10);
            end
            sink_wait     <= (w == 0) ? 0 : w - 1;
            m_axis_tready <= (w == 0) && (stall_left == 0);
        end else if (sink_wait != 0) begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Hold the receiver off once so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && names_seen >= STALL_AFTER) begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Predict on requests, check on results
    always @(posedge i_clk) begin
        t_short_name want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_name_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[27:8]);
            if (m_axis_tvalid && m_axis_tready) begin
                names_seen <= names_seen + 1;
                if (short_name_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected short name: %h", m_axis_tdata);
                end else begin
                    want = short_name_q.pop_front();
                    check_field("base_chars", want.base_chars, m_axis_tdata[63:0]);
                    check_field("base_length", 64'(want.base_length), 64'(m_axis_tdata[67:64]));
                    check_field("ext_chars", 64'(want.ext_chars), 64'(m_axis_tdata[91:68]));
                    check_field("ext_length", 64'(want.ext_length), 64'(m_axis_tdata[93:92]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] txt[$];
        int         form;
        int         n;

        add_text("aZ.9z", 20'd0);
        txt = '{8'h00, 8'hFF, 8'h80, fsng_pkg::CHAR_ZERO};
        add_name(txt, 20'hFFFFF);
        add_text("ABCDEFGHI", 20'd7);
        add_text("k.", 20'd999999);
        add_text("1.2.3", 20'd3);
        add_text(".", 20'd1);

        while (name_req_q.size() < NAME_BYTES) begin
            txt.delete();
            form = $urandom_range(0, 9);
            if (form < 6) begin
                n = (form == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
                repeat (n) txt.push_back(alnum_char());
                if (form != 5) begin
                    txt.push_back(fsng_pkg::CHAR_DOT);
                    n = $urandom_range(0, 5);
                    repeat (n) txt.push_back(alnum_char());
                end
            end else begin
                n = $urandom_range(1, 16);
                repeat (n) txt.push_back(noise_char());
            end
            if (txt.size() == 0) txt.push_back(alnum_char());
            add_name(txt, draw_tail());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (name_req_q.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (short_name_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
src/fsng_pkg.sv
src/fat_short_name_generator_unit.sv
tb/fat_short_name_generator_unit_tb.sv
